[hdl/scc_pkg.sv]
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types for the segment/circle crossing finder: controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Controller states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SQ_R   = 11'b000_0000_0010,
    ST_SQ_AC  = 11'b000_0000_0100,
    ST_SQ_BC  = 11'b000_0000_1000,
    ST_SQ_AB  = 11'b000_0001_0000,
    ST_ENTRY  = 11'b000_0010_0000,
    ST_LIM    = 11'b000_0100_0000,
    ST_PROBE  = 11'b000_1000_0000,
    ST_SQP    = 11'b001_0000_0000,
    ST_CMP    = 11'b010_0000_0000,
    ST_FINISH = 11'b100_0000_0000
  } state_e;

  // Operand pair fed to the two squarers
  typedef enum logic [2:0] {
    SQ_SEL_R  = 3'd0,  // radius, zero
    SQ_SEL_AC = 3'd1,  // start - center
    SQ_SEL_BC = 3'd2,  // end - center
    SQ_SEL_AB = 3'd3,  // end - start
    SQ_SEL_PC = 3'd4   // probe - center
  } sq_sel_e;

  // Register that captures the sum of the two squares
  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_R2   = 3'd1,
    DST_AC   = 3'd2,
    DST_BC   = 3'd3,
    DST_LAB  = 3'd4
  } dst_e;

  typedef struct packed {
    logic    load;        // capture input beat
    sq_sel_e sq_sel;
    dst_e    dst;
    logic    round_init;  // reset f, step, limit, round count, in/out points
    logic    round_upd;   // apply inside/outside decision
    logic    out_load;    // write result register
  } cmd_t;

  typedef struct packed {
    logic entry_ok;   // start strictly inside, end strictly outside
    logic round_go;   // another bisection round is due
    logic out_free;   // result register can take a new beat
  } status_t;

endpackage

[hdl/segment_circle_crossing_bisect.sv]
// ----------------------------------------------------------------------------
// segment_circle_crossing_bisect
// Finds where a segment leaves a circle by bisection along the segment.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid_i/s_axis_tready_o  tdata: segment + circle
//  m_axis    out  m_axis_tvalid_o/m_axis_tready_i  tdata: crossing, tuser: found
//
//  Sequencing: one item at a time; an item runs n bisection rounds, n up to
//  min(MAX_ROUNDS, FACTOR_FRAC_BITS), and a miss runs none. Each round is four
//  dependent register stages through the probe multiply, the shared squarers
//  and the compare.
//  Reset: async active low, clears the sequencer and the result valid.
//  Stalls: a result waits in its register while the next beat is accepted
//  and worked on; only the final write waits for the register to free up.
// ----------------------------------------------------------------------------
module segment_circle_crossing_bisect #(
  parameter int COORD_BITS       = 16,
  parameter int COORD_FRAC_BITS  = 4,
  parameter int FACTOR_FRAC_BITS = 16,
  parameter int MAX_ROUNDS       = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // start_x, start_y, end_x, end_y, center_x, center_y, radius, zero pad
  input  logic [((7*COORD_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // cross_x, cross_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // found
  output logic                     m_axis_tuser_o
);

  localparam int CB    = COORD_BITS;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  scc_pkg::cmd_t    cmd;
  scc_pkg::status_t status;
  logic signed [CB-1:0] cross_x, cross_y;

  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  scc_dp #(
    .COORD_BITS       (COORD_BITS),
    .COORD_FRAC_BITS  (COORD_FRAC_BITS),
    .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS),
    .MAX_ROUNDS       (MAX_ROUNDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .start_x_i   ($signed(s_axis_tdata_i[0*CB +: CB])),
    .start_y_i   ($signed(s_axis_tdata_i[1*CB +: CB])),
    .end_x_i     ($signed(s_axis_tdata_i[2*CB +: CB])),
    .end_y_i     ($signed(s_axis_tdata_i[3*CB +: CB])),
    .center_x_i  ($signed(s_axis_tdata_i[4*CB +: CB])),
    .center_y_i  ($signed(s_axis_tdata_i[5*CB +: CB])),
    .radius_i    (s_axis_tdata_i[6*CB +: CB]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .found_o     (m_axis_tuser_o),
    .cross_x_o   (cross_x),
    .cross_y_o   (cross_y)
  );

  // pack result beat, crossing x in the low bits
  assign m_axis_tdata_o = OUT_W'({cross_y, cross_x});

endmodule

[hdl/scc_ctrl.sv]
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer: setup squares, entry test, bisection rounds, result write.
// ----------------------------------------------------------------------------
module scc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  scc_pkg::status_t   status_i,
  output scc_pkg::cmd_t      cmd_o
);

  scc_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == scc_pkg::ST_IDLE);

  always_comb begin
    state_d           = state_q;
    cmd_o.load        = 1'b0;
    cmd_o.sq_sel      = scc_pkg::SQ_SEL_PC;
    cmd_o.dst         = scc_pkg::DST_NONE;
    cmd_o.round_init  = 1'b0;
    cmd_o.round_upd   = 1'b0;
    cmd_o.out_load    = 1'b0;
    unique case (state_q)
      scc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = scc_pkg::ST_SQ_R;
        end
      end
      scc_pkg::ST_SQ_R: begin
        cmd_o.sq_sel = scc_pkg::SQ_SEL_R;
        state_d      = scc_pkg::ST_SQ_AC;
      end
      scc_pkg::ST_SQ_AC: begin
        cmd_o.sq_sel = scc_pkg::SQ_SEL_AC;
        cmd_o.dst    = scc_pkg::DST_R2;
        state_d      = scc_pkg::ST_SQ_BC;
      end
      scc_pkg::ST_SQ_BC: begin
        cmd_o.sq_sel = scc_pkg::SQ_SEL_BC;
        cmd_o.dst    = scc_pkg::DST_AC;
        state_d      = scc_pkg::ST_SQ_AB;
      end
      scc_pkg::ST_SQ_AB: begin
        cmd_o.sq_sel = scc_pkg::SQ_SEL_AB;
        cmd_o.dst    = scc_pkg::DST_BC;
        state_d      = scc_pkg::ST_ENTRY;
      end
      scc_pkg::ST_ENTRY: begin
        cmd_o.dst        = scc_pkg::DST_LAB;
        cmd_o.round_init = 1'b1;
        state_d = status_i.entry_ok ? scc_pkg::ST_LIM : scc_pkg::ST_FINISH;
      end
      scc_pkg::ST_LIM: begin
        state_d = status_i.round_go ? scc_pkg::ST_PROBE : scc_pkg::ST_FINISH;
      end
      scc_pkg::ST_PROBE: begin
        state_d = scc_pkg::ST_SQP;
      end
      scc_pkg::ST_SQP: begin
        state_d = scc_pkg::ST_CMP;
      end
      scc_pkg::ST_CMP: begin
        cmd_o.round_upd = 1'b1;
        state_d         = scc_pkg::ST_LIM;
      end
      scc_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = scc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/scc_dp.sv]
// ----------------------------------------------------------------------------
// scc_dp
// Datapath: two squarers, two probe multipliers, compare logic, bisection
// registers and the result register.
// ----------------------------------------------------------------------------
module scc_dp #(
  parameter int COORD_BITS       = 16,
  parameter int COORD_FRAC_BITS  = 4,
  parameter int FACTOR_FRAC_BITS = 16,
  parameter int MAX_ROUNDS       = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  scc_pkg::cmd_t                cmd_i,
  output scc_pkg::status_t             status_o,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic        [COORD_BITS-1:0] radius_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic                         found_o,
  output logic signed [COORD_BITS-1:0] cross_x_o,
  output logic signed [COORD_BITS-1:0] cross_y_o
);

  localparam int CB   = COORD_BITS;
  localparam int FFB  = FACTOR_FRAC_BITS;
  localparam int CAP  = (MAX_ROUNDS < FFB) ? MAX_ROUNDS : FFB;
  localparam int DW   = CB + 1;                      // coordinate difference
  localparam int SQW  = 2 * DW;                      // sum of two squares
  localparam int LIMW = 2 * CAP + 2 * COORD_FRAC_BITS - 1;
  localparam int CMPW = (SQW > LIMW) ? SQW : LIMW;
  localparam int PW   = DW + FFB + 1;                // d * f product
  localparam int KW   = $clog2(CAP + 2);

  // input and derived differences
  logic signed [CB-1:0]  ax_q, ay_q, bx_q, by_q;
  logic        [CB-1:0]  r_q;
  logic signed [DW-1:0]  acx_q, acy_q, bcx_q, bcy_q, dx_q, dy_q;

  // squares
  logic signed [DW-1:0]  sq_in0, sq_in1;
  logic        [DW-1:0]  mag0, mag1;
  logic        [SQW-1:0] sq0_q, sq1_q, sum_w;
  logic        [SQW-1:0] r2_q, dac_q, dbc_q, lab_q;

  // bisection
  logic        [FFB-1:0]  f_q, step_q;
  logic        [CMPW-1:0] lim_q;
  logic        [KW-1:0]   k_q;
  logic signed [PW-1:0]   prodx_q, prody_q, shx, shy, pfx, pfy, pcfx, pcfy;
  logic signed [CB-1:0]   px_q, py_q, inx_q, iny_q, outx_q, outy_q;
  logic signed [DW-1:0]   pcx_q, pcy_q, midx, midy;
  logic                   found_q, outside;
  logic                   out_valid_q;

  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FFB - 1);

  always_comb begin
    unique case (cmd_i.sq_sel)
      scc_pkg::SQ_SEL_R:  begin sq_in0 = $signed({1'b0, r_q}); sq_in1 = '0;    end
      scc_pkg::SQ_SEL_AC: begin sq_in0 = acx_q;                sq_in1 = acy_q; end
      scc_pkg::SQ_SEL_BC: begin sq_in0 = bcx_q;                sq_in1 = bcy_q; end
      scc_pkg::SQ_SEL_AB: begin sq_in0 = dx_q;                 sq_in1 = dy_q;  end
      scc_pkg::SQ_SEL_PC: begin sq_in0 = pcx_q;                sq_in1 = pcy_q; end
      default:            begin sq_in0 = pcx_q;                sq_in1 = pcy_q; end
    endcase
  end

  assign mag0  = sq_in0[DW-1] ? DW'(-sq_in0) : DW'(sq_in0);
  assign mag1  = sq_in1[DW-1] ? DW'(-sq_in1) : DW'(sq_in1);
  assign sum_w = sq0_q + sq1_q;

  // probe = a + floor((d*f + half) / 2^FFB), and the same offset from (a - c)
  assign shx  = (prodx_q + HALF) >>> FFB;
  assign shy  = (prody_q + HALF) >>> FFB;
  assign pfx  = PW'(ax_q) + shx;
  assign pfy  = PW'(ay_q) + shy;
  assign pcfx = PW'(acx_q) + shx;
  assign pcfy = PW'(acy_q) + shy;

  assign outside = (sum_w > r2_q);

  // floor midpoint of last inside and outside probes (segment ends before any)
  assign midx = (DW'(inx_q) + DW'(outx_q)) >>> 1;
  assign midy = (DW'(iny_q) + DW'(outy_q)) >>> 1;

  assign status_o.entry_ok = (dac_q < r2_q) && (dbc_q > r2_q);
  assign status_o.round_go = (k_q <= KW'(CAP)) && (CMPW'(lab_q) > lim_q);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q  <= start_x_i;
      ay_q  <= start_y_i;
      bx_q  <= end_x_i;
      by_q  <= end_y_i;
      r_q   <= radius_i;
      acx_q <= DW'(start_x_i) - DW'(center_x_i);
      acy_q <= DW'(start_y_i) - DW'(center_y_i);
      bcx_q <= DW'(end_x_i) - DW'(center_x_i);
      bcy_q <= DW'(end_y_i) - DW'(center_y_i);
      dx_q  <= DW'(end_x_i) - DW'(start_x_i);
      dy_q  <= DW'(end_y_i) - DW'(start_y_i);
    end

    sq0_q   <= SQW'(mag0) * SQW'(mag0);
    sq1_q   <= SQW'(mag1) * SQW'(mag1);
    prodx_q <= dx_q * $signed({1'b0, f_q});
    prody_q <= dy_q * $signed({1'b0, f_q});
    px_q    <= pfx[CB-1:0];
    py_q    <= pfy[CB-1:0];
    pcx_q   <= pcfx[DW-1:0];
    pcy_q   <= pcfy[DW-1:0];

    unique case (cmd_i.dst)
      scc_pkg::DST_NONE: ;
      scc_pkg::DST_R2:   r2_q  <= sum_w;
      scc_pkg::DST_AC:   dac_q <= sum_w;
      scc_pkg::DST_BC:   dbc_q <= sum_w;
      scc_pkg::DST_LAB:  lab_q <= sum_w;
      default: ;
    endcase

    if (cmd_i.round_init) begin
      found_q <= status_o.entry_ok;
      f_q     <= FFB'(1) << (FFB - 1);
      step_q  <= FFB'(1) << (FFB - 2);
      lim_q   <= CMPW'(1) << (2 * COORD_FRAC_BITS);
      inx_q   <= ax_q;
      iny_q   <= ay_q;
      outx_q  <= bx_q;
      outy_q  <= by_q;
    end else if (cmd_i.round_upd) begin
      step_q <= step_q >> 1;
      lim_q  <= lim_q << 2;
      if (outside) begin
        outx_q <= px_q;
        outy_q <= py_q;
        f_q    <= f_q - step_q;
      end else begin
        inx_q <= px_q;
        iny_q <= py_q;
        f_q   <= f_q + step_q;
      end
    end

    if (cmd_i.out_load) begin
      found_o   <= found_q;
      cross_x_o <= found_q ? midx[CB-1:0] : '0;
      cross_y_o <= found_q ? midy[CB-1:0] : '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.round_init) begin
        k_q <= KW'(1);
      end else if (cmd_i.round_upd) begin
        k_q <= k_q + KW'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // a held result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while held");

  // rounds never run past the cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round_upd |-> (k_q <= KW'(CAP)))
    else $error("bisection round beyond cap");

  // a miss always reports the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load && !found_q |=> (cross_x_o == '0) && (cross_y_o == '0))
    else $error("miss with nonzero crossing");

endmodule
